// ----- sv/tffb_pkg.sv -----
// ----------------------------------------------------------------------------
// tffb_pkg
// Shared types and constants for the tile fetch from bitmap unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tffb_pkg;

	// store and layout constants
	localparam int TFFB_STORE_BYTES  = 4096;
	localparam int MAX_MAP_WIDTH     = 64;
	localparam int TILE_EDGE         = 8;
	localparam int TILE_PIXELS       = TILE_EDGE * TILE_EDGE;

	// field widths
	localparam int LOAD_ADDR_W  = 12;
	localparam int TILE_NUM_W   = 10;
	localparam int WIDTH_W      = 7;
	localparam int LENGTH_W     = 13;
	localparam int POS_W        = 6;

	// divider, product and address widths
	localparam int STRIDE_W = WIDTH_W + 3;
	localparam int PROD_W   = STRIDE_W + TILE_NUM_W;
	localparam int TL_W     = PROD_W + 4;
	localparam int LIMIT_W  = 17;

	// apb port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_LENGTH = 2'd2;

	// opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	// register reset values
	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 7'd1;
	localparam logic [LENGTH_W-1:0] LENGTH_RESET = 13'd4096;

	typedef struct packed {
		logic                    opcode;
		logic [LOAD_ADDR_W-1:0]  load_address;
		logic [7:0]              load_byte;
		logic [TILE_NUM_W-1:0]   tile_num;
	} item_t;

	typedef struct packed {
		logic [7:0]       pixel_value;
		logic [POS_W-1:0] pixel_position;
		logic             fetch_error;
		logic             last;
	} result_t;

	typedef struct packed {
		logic                mode_8bpp;
		logic [WIDTH_W-1:0]  map_width_tiles;
		logic [LENGTH_W-1:0] buffer_length;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load_wr;
		logic div_init;
		logic div_step;
		logic mul;
		logic load_base;
		logic pix_read;
		logic emit_err;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic width_zero;
		logic range_err;
		logic last_pix;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- sv/tffb_regs.sv -----
// ----------------------------------------------------------------------------
// tffb_regs
// APB configuration registers: pixel depth, map width, buffer length.
// ----------------------------------------------------------------------------
`default_nettype none

module tffb_regs
	import tffb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	logic                mode_q;
	logic [WIDTH_W-1:0]  width_q;
	logic [LENGTH_W-1:0] length_q;
	logic                wr_en;
	logic [1:0]          reg_sel;
	logic [WIDTH_W-1:0]  width_in;
	logic [WIDTH_W-1:0]  width_sat;

	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite;
	assign reg_sel  = paddr[3:2];
	assign width_in = pwdata[WIDTH_W-1:0];

	// widths above the maximum saturate
	assign width_sat = ({2'b00, width_in} > 9'(MAX_MAP_WIDTH)) ?
		WIDTH_W'(MAX_MAP_WIDTH) : width_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			width_q  <= WIDTH_RESET;
			length_q <= LENGTH_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_MODE:   mode_q   <= pwdata[0];
				REG_WIDTH:  width_q  <= width_sat;
				REG_LENGTH: length_q <= pwdata[LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_MODE:   prdata = {31'd0, mode_q};
			REG_WIDTH:  prdata = {25'd0, width_q};
			REG_LENGTH: prdata = {19'd0, length_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.mode_8bpp       = mode_q;
	assign cfg.map_width_tiles = width_q;
	assign cfg.buffer_length   = length_q;

endmodule

`default_nettype wire

// ----- sv/tffb_ctrl.sv -----
// ----------------------------------------------------------------------------
// tffb_ctrl
// Sequencer for loads and tile fetches: divide, multiply, check, stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tffb_ctrl
	import tffb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       opcode,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd,
	output logic            busy
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_RUN   = 3'd4;
	localparam logic [2:0] S_ERR   = 3'd5;

	localparam logic [3:0] DIV_LAST = 4'(TILE_NUM_W - 1);

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic [3:0] div_cnt_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (opcode == OP_LOAD) begin
						cmd.load_wr = 1'b1;
					end else if (status.width_zero) begin
						state_nxt = S_ERR;
					end else begin
						cmd.div_init = 1'b1;
						state_nxt    = S_DIV;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_nxt = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = S_CHECK;
			end
			S_CHECK: begin
				if (status.range_err) begin
					state_nxt = S_ERR;
				end else begin
					cmd.load_base = 1'b1;
					state_nxt     = S_RUN;
				end
			end
			S_RUN: begin
				cmd.pix_read = 1'b1;
				if (status.last_pix) begin
					state_nxt = S_IDLE;
				end
			end
			S_ERR: begin
				cmd.emit_err = 1'b1;
				state_nxt    = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q + 4'd1;
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ----- sv/tffb_datapath.sv -----
// ----------------------------------------------------------------------------
// tffb_datapath
// Bitmap store, tile index divider, address generator and pixel output.
// ----------------------------------------------------------------------------
`default_nettype none

module tffb_datapath
	import tffb_pkg::*;
#(
	parameter int STORE_BYTES = TFFB_STORE_BYTES
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire item_t   item,
	input  wire dp_cmd_t cmd,
	output dp_status_t   status,
	output result_t      result,
	output logic         result_valid
);

	localparam int ADDR_W = $clog2(STORE_BYTES);

	logic [7:0]              store_q [STORE_BYTES];

	logic [TILE_NUM_W-1:0]   quot_q;
	logic [WIDTH_W-1:0]      rem_q;
	logic [PROD_W-1:0]       prod_q;
	logic [8:0]              colofs_q;
	logic [TL_W-1:0]         row_addr_q;
	logic [POS_W-1:0]        pix_cnt_q;

	logic [7:0]              rdata_s1;
	logic [POS_W-1:0]        pos_s1;
	logic                    valid_s1;

	result_t                 result_q;
	logic                    result_valid_q;

	logic [STRIDE_W-1:0]     stride;
	logic [3:0]              span;
	logic [WIDTH_W:0]        trial;
	logic                    trial_ge;
	logic [WIDTH_W-1:0]      rem_nxt;
	logic [STRIDE_W+2:0]     seven_stride;
	logic [TL_W-1:0]         top_left;
	logic [TL_W-1:0]         bottom_right;
	logic [LIMIT_W-1:0]      limit;
	logic [2:0]              col;
	logic [2:0]              col_off;
	logic [TL_W-1:0]         rd_full;
	logic [ADDR_W-1:0]       rd_addr;
	logic [ADDR_W-1:0]       wr_addr;
	logic                    wr_in_range;
	logic [7:0]              pix_value;

	// one tile row is 4 bytes at 4bpp, 8 bytes at 8bpp
	assign span   = cfg.mode_8bpp ? 4'd8 : 4'd4;
	assign stride = cfg.mode_8bpp ? {cfg.map_width_tiles, 3'b000}
		: {1'b0, cfg.map_width_tiles, 2'b00};

	// restoring divider, one quotient bit per step
	assign trial    = {rem_q, quot_q[TILE_NUM_W-1]};
	assign trial_ge = (trial >= {1'b0, cfg.map_width_tiles});
	assign rem_nxt  = trial_ge ? WIDTH_W'(trial - {1'b0, cfg.map_width_tiles})
		: trial[WIDTH_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			quot_q <= item.tile_num;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[TILE_NUM_W-2:0], trial_ge};
			rem_q  <= rem_nxt;
		end
	end

	// grid row times stride, grid column times span
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q   <= stride * quot_q;
			colofs_q <= cfg.mode_8bpp ? {rem_q[5:0], 3'b000} : {1'b0, rem_q[5:0], 2'b00};
		end
	end

	assign top_left     = TL_W'({prod_q, 3'b000}) + TL_W'(colofs_q);
	assign seven_stride = {stride, 3'b000} - (STRIDE_W+3)'(stride);
	assign bottom_right = top_left + TL_W'(span) + TL_W'(seven_stride);

	assign limit = (LIMIT_W'(cfg.buffer_length) > LIMIT_W'(STORE_BYTES)) ?
		LIMIT_W'(STORE_BYTES) : LIMIT_W'(cfg.buffer_length);

	assign status.width_zero = (cfg.map_width_tiles == '0);
	assign status.range_err  = (bottom_right > TL_W'(limit));
	assign status.last_pix   = (pix_cnt_q == POS_W'(TILE_PIXELS - 1));

	// pixel address walk
	assign col     = pix_cnt_q[2:0];
	assign col_off = cfg.mode_8bpp ? col : {1'b0, col[2:1]};
	assign rd_full = row_addr_q + TL_W'(col_off);
	assign rd_addr = ADDR_W'(rd_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_cnt_q  <= '0;
			row_addr_q <= '0;
		end else if (cmd.load_base) begin
			pix_cnt_q  <= '0;
			row_addr_q <= top_left;
		end else if (cmd.pix_read) begin
			pix_cnt_q <= pix_cnt_q + POS_W'(1);
			if (col == 3'd7) begin
				row_addr_q <= row_addr_q + TL_W'(stride);
			end
		end
	end

	// bitmap store
	assign wr_addr     = ADDR_W'(item.load_address);
	assign wr_in_range = (LIMIT_W'(item.load_address) < LIMIT_W'(STORE_BYTES));

	always_ff @(posedge clk) begin
		if (cmd.load_wr && wr_in_range) begin
			store_q[wr_addr] <= item.load_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_read) begin
			rdata_s1 <= store_q[rd_addr];
			pos_s1   <= pix_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.pix_read;
		end
	end

	// low nibble first at 4bpp
	assign pix_value = cfg.mode_8bpp ? rdata_s1
		: (pos_s1[0] ? {4'h0, rdata_s1[7:4]} : {4'h0, rdata_s1[3:0]});

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q.pixel_value    <= pix_value;
			result_q.pixel_position <= pos_s1;
			result_q.fetch_error    <= 1'b0;
			result_q.last           <= (pos_s1 == POS_W'(TILE_PIXELS - 1));
		end else if (cmd.emit_err) begin
			result_q.pixel_value    <= '0;
			result_q.pixel_position <= '0;
			result_q.fetch_error    <= 1'b1;
			result_q.last           <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s1 || cmd.emit_err;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

// ----- sv/tile_fetch_from_bitmap_unit.sv -----
// ----------------------------------------------------------------------------
// tile_fetch_from_bitmap_unit
// Linear bitmap store with 8x8 tile extraction at 4 or 8 bits per pixel.
// ----------------------------------------------------------------------------
// load: no result, busy stays low, one load per cycle
// fetch: 10 divide steps, a multiply and a range check, then one store read
//   and one pixel per cycle; each pixel passes a store read register and an
//   output register on its way to the result port; busy stays high until the
//   last store read, and no new beat is taken until then; the single store
//   read port sets the pixel rate
// out of range: one error beat after the check (from idle if width is zero)
// results are strobed for one cycle each; the receiver cannot stall
// arst_n clears the controller, counters, config registers and valid flags; the store is not cleared
`default_nettype none

module tile_fetch_from_bitmap_unit
	import tffb_pkg::*;
#(
	parameter int STORE_BYTES = TFFB_STORE_BYTES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,

	// command side
	input  wire logic                  start,
	input  wire item_t                 item,
	output logic                       busy,

	// result side
	output logic                       result_valid,
	output result_t                    result
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	// configuration registers; to be written only while the unit is idle, which the block itself does not enforce
	tffb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: accepts a beat only while idle
	tffb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.opcode  (item.opcode),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy)
	);

	// store, divider, address walk and output register
	tffb_datapath #(
		.STORE_BYTES (STORE_BYTES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

`default_nettype wire
